>>> rtl/ivc_pkg.sv
// shared types and constants for the incremental vector covariance block
// no dependencies

package ivc_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CovW  = 64;
  localparam int unsigned LenW  = 11;
  localparam logic [31:0] CountMax = 32'hFFFF_FFFF;

  // register addresses (word index)
  localparam logic [0:0] RegVectorLength = 1'b0;

  // datapath operations issued by the controller
  typedef enum logic [5:0] {
    OP_IDLE  = 6'b000001,
    OP_LOAD  = 6'b000010,
    OP_DIFF  = 6'b000100,
    OP_MUL   = 6'b001000,
    OP_DIV   = 6'b010000,
    OP_WRITE = 6'b100000
  } dp_op_t;

  typedef struct packed {
    dp_op_t      op;
    logic        div_start;
    logic [1:0]  div_sel;    // 0 cov magnitude, 1 product, 2 dx, 3 dy
    logic        update_cov;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_status_t;

  localparam logic [1:0] DivCov  = 2'd0;
  localparam logic [1:0] DivProd = 2'd1;
  localparam logic [1:0] DivDx   = 2'd2;
  localparam logic [1:0] DivDy   = 2'd3;

endpackage

>>> rtl/incremental_vector_covariance.sv
// top level: running per-element covariance and means with APB register
// depends on ivc_pkg, ivc_controller, ivc_datapath
//
//  channel   direction  handshake         payload
//  samples   in         in_valid/ready    x_sample, y_sample
//  results   out        out_valid/ready   covariance_value, mean_x, mean_y, end_of_vector
//  config    in         apb psel/penable  vector_length at address 0
//
// from the third vector on, four divisions per element share one divider
// in the first two vectors only the two mean divisions run
// after reset a clearing sweep over all MAX_ELEMENTS addresses zeroes the stores
// input is refused during the sweep and while an element is in work
// a waiting result blocks the next transfer until taken

module incremental_vector_covariance #(
  parameter int unsigned MAX_ELEMENTS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] x_sample,
  input  logic signed [31:0] y_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] covariance_value,
  output logic signed [31:0] mean_x,
  output logic signed [31:0] mean_y,
  output logic               end_of_vector,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned PosW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

  logic [10:0]          vector_length;
  ivc_pkg::dp_cmd_t     cmd;
  ivc_pkg::dp_status_t  status;
  logic [PosW-1:0]      pos, clr_addr;
  logic [31:0]          n;
  logic                 clr_en;
  logic signed [31:0]   x_hold, y_hold;

  assign pready = 1'b1;
  assign prdata = (paddr[1:1] == ivc_pkg::RegVectorLength) ? 32'(vector_length) : '0;

  always_ff @(posedge clk) begin
    if (rst) vector_length <= 11'd1024;
    else if (psel && penable && pwrite && paddr[1:1] == ivc_pkg::RegVectorLength)
      vector_length <= pwdata[10:0];
  end

  // hold the accepted sample pair while the element is in work
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_hold <= x_sample;
      y_hold <= y_sample;
    end
  end

  ivc_controller #(.MaxElements(MAX_ELEMENTS), .PosW(PosW)) u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_valid && in_ready), .in_ready(in_ready),
    .res_valid(out_valid), .res_ready(out_ready), .vector_length(vector_length),
    .status(status), .cmd(cmd), .pos(pos), .n(n), .last(end_of_vector),
    .clr_addr(clr_addr), .clr_en(clr_en)
  );

  ivc_datapath #(.MaxElements(MAX_ELEMENTS), .PosW(PosW)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .pos(pos), .n(n),
    .x_in(x_hold), .y_in(y_hold), .clr_addr(clr_addr), .clr_en(clr_en),
    .cov_out(covariance_value), .mx_out(mean_x), .my_out(mean_y)
  );

endmodule

>>> rtl/ivc_divider.sv
// radix-2 restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle
// no dependencies

module ivc_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient,
  output logic        rem_nonzero
);

  logic [63:0] quo;
  logic [32:0] rem;
  logic [6:0]  count;
  logic        busy;
  logic [32:0] trial;
  logic [32:0] shifted;

  always_comb begin
    shifted = {rem[31:0], quo[63]};
    trial   = shifted - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= 7'd0;
        quo   <= dividend;
        rem   <= '0;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial;
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[62:0], 1'b0};
        end
        count <= count + 7'd1;
        if (count == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient    = quo;
  assign rem_nonzero = (rem != '0);

endmodule

>>> rtl/ivc_datapath.sv
// datapath: element stores, differences, product, divider use, saturation
// depends on ivc_pkg, ivc_divider

module ivc_datapath #(
  parameter int unsigned MaxElements = 1024,
  parameter int unsigned PosW = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  ivc_pkg::dp_cmd_t   cmd,
  output ivc_pkg::dp_status_t status,
  input  logic [PosW-1:0]    pos,
  input  logic [31:0]        n,
  input  logic signed [31:0] x_in,
  input  logic signed [31:0] y_in,
  input  logic [PosW-1:0]    clr_addr,
  input  logic               clr_en,
  output logic signed [63:0] cov_out,
  output logic signed [31:0] mx_out,
  output logic signed [31:0] my_out
);

  logic [63:0] cov_mem [MaxElements];
  logic [31:0] mx_mem  [MaxElements];
  logic [31:0] my_mem  [MaxElements];

  logic signed [63:0] cov_rd;
  logic signed [31:0] mx_rd, my_rd;
  logic signed [32:0] dx, dy;
  logic [31:0] dx_abs, dy_abs;
  logic [63:0] cov_mag, prod, div_in;
  logic        cov_neg, prod_neg;
  logic [63:0] q;
  logic        q_rnz, div_done;
  logic [63:0] sm, term_q;
  logic signed [64:0] sum;
  logic signed [63:0] cov_sat;
  logic signed [31:0] mx_new, my_new;

  always_ff @(posedge clk) begin
    if (clr_en) begin
      cov_mem[clr_addr] <= '0;
      mx_mem[clr_addr]  <= '0;
      my_mem[clr_addr]  <= '0;
    end else if (cmd.op == ivc_pkg::OP_WRITE) begin
      if (cmd.update_cov) cov_mem[pos] <= cov_sat;
      mx_mem[pos] <= mx_new;
      my_mem[pos] <= my_new;
    end
    cov_rd <= cov_mem[pos];
    mx_rd  <= mx_mem[pos];
    my_rd  <= my_mem[pos];
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      ivc_pkg::OP_LOAD: begin
        cov_out <= cov_rd;
        mx_out  <= mx_rd;
        my_out  <= my_rd;
      end
      ivc_pkg::OP_DIFF: begin
        dx      <= {x_in[31], x_in} - {mx_out[31], mx_out};
        dy      <= {y_in[31], y_in} - {my_out[31], my_out};
        cov_neg <= cov_out[63];
        cov_mag <= cov_out[63] ? 64'(-cov_out) : 64'(cov_out);
      end
      ivc_pkg::OP_MUL: begin
        prod     <= 64'(dx_abs) * 64'(dy_abs);
        prod_neg <= dx[32] != dy[32];
      end
      default: ;
    endcase
    if (div_done) begin
      case (cmd.div_sel)
        ivc_pkg::DivCov:  sm     <= cov_mag - q - 64'(q_rnz);
        ivc_pkg::DivProd: term_q <= q;
        ivc_pkg::DivDx:   mx_new <= mx_out + 32'(dx[32] ? -$signed({1'b0, q[32:0]})
                                                        : $signed({1'b0, q[32:0]}));
        default:          my_new <= my_out + 32'(dy[32] ? -$signed({1'b0, q[32:0]})
                                                        : $signed({1'b0, q[32:0]}));
      endcase
    end
    if (cmd.op == ivc_pkg::OP_WRITE && cmd.update_cov) cov_out <= cov_sat;
    if (cmd.op == ivc_pkg::OP_WRITE) begin
      mx_out <= mx_new;
      my_out <= my_new;
    end
  end

  always_comb begin
    dx_abs = 32'(dx[32] ? -dx : dx);
    dy_abs = 32'(dy[32] ? -dy : dy);
    sum = (cov_neg ? -$signed({1'b0, sm}) : $signed({1'b0, sm}))
        + (prod_neg ? -$signed({1'b0, term_q}) : $signed({1'b0, term_q}));
    if (sum > 65'sh0_7FFF_FFFF_FFFF_FFFF)       cov_sat = 64'h7FFF_FFFF_FFFF_FFFF;
    else if (sum < -65'sh0_8000_0000_0000_0000) cov_sat = 64'h8000_0000_0000_0000;
    else                                        cov_sat = sum[63:0];
    case (cmd.div_sel)
      ivc_pkg::DivCov:  div_in = cov_mag;
      ivc_pkg::DivProd: div_in = prod;
      ivc_pkg::DivDx:   div_in = 64'(dx_abs);
      default:          div_in = 64'(dy_abs);
    endcase
  end

  ivc_divider u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(div_in), .divisor(n),
    .done(div_done), .quotient(q), .rem_nonzero(q_rnz)
  );

  assign status.div_done = div_done;

endmodule

>>> rtl/ivc_controller.sv
// controller: clearing sweep, element sequencing, handshakes
// depends on ivc_pkg

module ivc_controller #(
  parameter int unsigned MaxElements = 1024,
  parameter int unsigned PosW = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_fire,
  output logic                in_ready,
  output logic                res_valid,
  input  logic                res_ready,
  input  logic [10:0]         vector_length,
  input  ivc_pkg::dp_status_t status,
  output ivc_pkg::dp_cmd_t    cmd,
  output logic [PosW-1:0]     pos,
  output logic [31:0]         n,
  output logic                last,
  output logic [PosW-1:0]     clr_addr,
  output logic                clr_en
);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_RD    = 9'b000000100,
    S_LOAD  = 9'b000001000,
    S_DIFF  = 9'b000010000,
    S_MUL   = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_OUT   = 9'b010000000,
    S_WR    = 9'b100000000
  } state_t;

  state_t      state;
  logic [1:0]  div_sel;
  logic        div_go;
  logic [31:0] count;
  logic [16:0] len_eff;
  logic        use_cov;

  always_comb begin
    len_eff = (vector_length == 11'd0) ? 17'd1 : 17'(vector_length);
    if (len_eff > 17'(MaxElements)) len_eff = 17'(MaxElements);
  end

  assign use_cov = n > 32'd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      pos      <= '0;
      count    <= '0;
      n        <= 32'd1;
      div_go   <= 1'b0;
      div_sel  <= ivc_pkg::DivCov;
      last     <= 1'b0;
    end else begin
      div_go <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + PosW'(1);
          if (32'(clr_addr) == MaxElements - 1) state <= S_IDLE;
        end
        S_IDLE: if (in_fire) begin
          if (pos == '0) begin
            if (count != ivc_pkg::CountMax) begin
              count <= count + 32'd1;
              n     <= count + 32'd1;
            end
          end
          state <= S_RD;
        end
        S_RD:   state <= S_LOAD;
        S_LOAD: state <= S_DIFF;
        S_DIFF: state <= S_MUL;
        S_MUL: begin
          div_sel <= use_cov ? ivc_pkg::DivCov : ivc_pkg::DivDx;
          div_go  <= 1'b1;
          state   <= S_DIV;
        end
        S_DIV: if (status.div_done) begin
          if (div_sel == ivc_pkg::DivDy) begin
            state <= S_WR;
          end else begin
            div_sel <= div_sel + 2'd1;
            div_go  <= 1'b1;
          end
        end
        S_WR: begin
          last  <= 17'(pos) + 17'd1 >= len_eff;
          pos   <= (17'(pos) + 17'd1 >= len_eff) ? '0 : pos + PosW'(1);
          state <= S_OUT;
        end
        S_OUT: if (res_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.div_start  = div_go;
    cmd.div_sel    = div_sel;
    cmd.update_cov = use_cov;
    case (state)
      S_LOAD:  cmd.op = ivc_pkg::OP_LOAD;
      S_DIFF:  cmd.op = ivc_pkg::OP_DIFF;
      S_MUL:   cmd.op = ivc_pkg::OP_MUL;
      S_DIV:   cmd.op = ivc_pkg::OP_DIV;
      S_WR:    cmd.op = ivc_pkg::OP_WRITE;
      default: cmd.op = ivc_pkg::OP_IDLE;
    endcase
  end

  assign in_ready  = state == S_IDLE;
  assign res_valid = state == S_OUT;
  assign clr_en    = state == S_CLEAR;

  a_one_side: assert property (@(posedge clk) disable iff (rst) !(in_ready && res_valid))
    else $error("input and result both open");
  a_n_pos: assert property (@(posedge clk) disable iff (rst) state != S_CLEAR |-> n != 32'd0)
    else $error("zero divisor");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped");

endmodule
